>>> hw/rtl/mfd_pkg.sv
`timescale 1ns / 1ps
package mfd_pkg;

  localparam int unsigned FaceCapacity = 4096;
  localparam int unsigned IdxW         = 12;
  localparam int unsigned TotW         = 13;
  localparam int unsigned Buckets      = 1024;
  localparam int unsigned BktW         = 10;
  localparam int unsigned VidW         = 32;
  localparam int unsigned FaceW        = 4 * VidW + 1;
  localparam int unsigned CntW         = 4;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] CLS_DROPPED     = 2'd0;
  localparam logic [1:0] CLS_OUTER_VIS   = 2'd1;
  localparam logic [1:0] CLS_INNER_VIS   = 2'd2;
  localparam logic [1:0] CLS_OUTER_INVIS = 2'd3;

  localparam logic [TotW-1:0] NIL_LINK = TotW'(FaceCapacity);

  typedef struct packed {
    logic [1:0]      operation;
    logic [VidW-1:0] vertex_0;
    logic [VidW-1:0] vertex_1;
    logic [VidW-1:0] vertex_2;
    logic [VidW-1:0] vertex_3;
    logic            is_quad;
    logic            cell_visible;
    logic [IdxW-1:0] face_select;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] face_index;
    logic            is_new;
    logic            table_full;
    logic [1:0]      face_class;
    logic [VidW-1:0] out_vertex_0;
    logic [VidW-1:0] out_vertex_1;
    logic [VidW-1:0] out_vertex_2;
    logic [VidW-1:0] out_vertex_3;
    logic            out_is_quad;
    logic [TotW-1:0] face_total;
  } res_t;

  // canonical command passed from front to back
  typedef struct packed {
    logic [1:0]      op;
    logic [VidW-1:0] c0;
    logic [VidW-1:0] c1;
    logic [VidW-1:0] c2;
    logic [VidW-1:0] c3;
    logic            quad;
    logic            vis;
    logic [IdxW-1:0] sel;
    logic [BktW-1:0] bucket;
  } cmd_t;

  function automatic logic [1:0] class_of(input logic [1:0] c, input logic [1:0] v);
    logic [1:0] cls;
    cls = CLS_DROPPED;
    if (c == 2'd1 && v == 2'd1) cls = CLS_OUTER_VIS;
    else if (c == 2'd2 && v == 2'd1) cls = CLS_INNER_VIS;
    else if (c == 2'd1 && v == 2'd0) cls = CLS_OUTER_INVIS;
    return cls;
  endfunction

endpackage

>>> hw/rtl/mfd_ram.sv
`timescale 1ns / 1ps
module mfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/mfd_front.sv
`timescale 1ns / 1ps
module mfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mfd_pkg::in_t  cmd_i,
  input  logic          hold_i,
  output logic          busy_o,
  output logic          push_o,
  input  logic          push_ready_i,
  output mfd_pkg::cmd_t push_data_o
);
  logic          valid_q, valid_d;
  mfd_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;

  logic [mfd_pkg::VidW-1:0] r0, r1, r2, r3, m;
  logic [1:0]               s;

  assign busy_o = hold_i | (valid_q & ~push_ready_i);
  assign accept = start_i & ~busy_o;
  assign push_o = valid_q;
  assign push_data_o = cmd_q;

  // rotate so the earliest minimum id leads
  always_comb begin
    r0 = cmd_i.vertex_0;
    r1 = cmd_i.vertex_1;
    r2 = cmd_i.vertex_2;
    r3 = cmd_i.is_quad ? cmd_i.vertex_3 : '0;
    s = 2'd0;
    m = r0;
    if (r1 < m) begin
      s = 2'd1;
      m = r1;
    end
    if (r2 < m) begin
      s = 2'd2;
      m = r2;
    end
    if (cmd_i.is_quad && r3 < m) begin
      s = 2'd3;
    end
    cmd_d = cmd_q;
    cmd_d.op   = cmd_i.operation;
    cmd_d.quad = cmd_i.is_quad;
    cmd_d.vis  = cmd_i.cell_visible;
    cmd_d.sel  = cmd_i.face_select;
    if (cmd_i.is_quad) begin
      case (s)
        2'd1: begin
          cmd_d.c0 = r1; cmd_d.c1 = r2; cmd_d.c2 = r3; cmd_d.c3 = r0;
        end
        2'd2: begin
          cmd_d.c0 = r2; cmd_d.c1 = r3; cmd_d.c2 = r0; cmd_d.c3 = r1;
        end
        2'd3: begin
          cmd_d.c0 = r3; cmd_d.c1 = r0; cmd_d.c2 = r1; cmd_d.c3 = r2;
        end
        default: begin
          cmd_d.c0 = r0; cmd_d.c1 = r1; cmd_d.c2 = r2; cmd_d.c3 = r3;
        end
      endcase
    end else begin
      cmd_d.c3 = '0;
      case (s)
        2'd1: begin
          cmd_d.c0 = r1; cmd_d.c1 = r2; cmd_d.c2 = r0;
        end
        2'd2: begin
          cmd_d.c0 = r2; cmd_d.c1 = r0; cmd_d.c2 = r1;
        end
        default: begin
          cmd_d.c0 = r0; cmd_d.c1 = r1; cmd_d.c2 = r2;
        end
      endcase
    end
    cmd_d.bucket = cmd_d.c0[mfd_pkg::BktW-1:0];
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) valid_d = 1'b1;
    else if (push_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_d;
  end
endmodule

>>> hw/rtl/mfd_queue.sv
`timescale 1ns / 1ps
module mfd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfd_pkg::cmd_t push_data_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output mfd_pkg::cmd_t pop_data_o
);
  mfd_pkg::cmd_t entry_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = entry_q[rd_q];
  assign do_push = push_i & push_ready_o;
  assign do_pop  = pop_i & pop_valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= push_data_i;
  end
endmodule

>>> hw/rtl/mfd_back.sv
`timescale 1ns / 1ps
module mfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mfd_pkg::cmd_t q_data_i,
  output logic          pop_o,
  output logic          sweeping_o,
  output logic          res_valid_o,
  output mfd_pkg::res_t res_o
);
  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_NEW   = 3'd4;
  localparam logic [2:0] ST_RDOUT = 3'd5;

  localparam int unsigned IdxW = mfd_pkg::IdxW;
  localparam int unsigned TotW = mfd_pkg::TotW;
  localparam int unsigned BktW = mfd_pkg::BktW;

  logic [2:0]      state_q, state_d;
  mfd_pkg::cmd_t   cmd_q, cmd_d;
  logic [TotW-1:0] p_q, p_d, head_q, head_d, total_q, total_d;
  logic [BktW-1:0] sweep_q, sweep_d;
  mfd_pkg::res_t   res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic [IdxW-1:0]         rd_addr;
  logic [mfd_pkg::FaceW-1:0] face_rdata, face_wdata;
  logic [TotW-1:0]         link_rdata, head_rdata;
  logic [mfd_pkg::CntW-1:0] cnt_rdata, cnt_wdata;
  logic                    face_we, cnt_we, head_we;
  logic [IdxW-1:0]         cnt_waddr;
  logic [BktW-1:0]         head_waddr;
  logic [TotW-1:0]         head_wdata;

  logic [mfd_pkg::VidW-1:0] b0, b1, b2, b3;
  logic       bq, match;
  logic [1:0] c_old, v_old, c_new, v_new;

  assign {b0, b1, b2, b3, bq} = face_rdata;
  assign {c_old, v_old} = cnt_rdata;
  assign c_new = (c_old == 2'd3) ? c_old : c_old + 2'd1;
  assign v_new = (cmd_q.vis && v_old != 2'd3) ? v_old + 2'd1 : v_old;

  always_comb begin
    match = (bq == cmd_q.quad) && (b0 == cmd_q.c0);
    if (cmd_q.quad) begin
      match = match && (cmd_q.c2 == b2) &&
              ((cmd_q.c1 == b1 && cmd_q.c3 == b3) || (cmd_q.c1 == b3 && cmd_q.c3 == b1));
    end else begin
      match = match &&
              ((cmd_q.c1 == b1 && cmd_q.c2 == b2) || (cmd_q.c1 == b2 && cmd_q.c2 == b1));
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE: rd_addr = q_data_i.sel;
      ST_HEAD: rd_addr = head_rdata[IdxW-1:0];
      ST_CMP:  rd_addr = link_rdata[IdxW-1:0];
      default: rd_addr = p_q[IdxW-1:0];
    endcase
  end

  assign pop_o      = (state_q == ST_IDLE) && q_valid_i;
  assign sweeping_o = (state_q == ST_SWEEP);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    p_d         = p_q;
    head_d      = head_q;
    total_d     = total_q;
    sweep_d     = sweep_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    face_we     = 1'b0;
    cnt_we      = 1'b0;
    head_we     = 1'b0;
    cnt_waddr   = p_q[IdxW-1:0];
    cnt_wdata   = {c_new, v_new};
    head_waddr  = cmd_q.bucket;
    head_wdata  = total_q;
    face_wdata  = {cmd_q.c0, cmd_q.c1, cmd_q.c2, cmd_q.c3, cmd_q.quad};
    case (state_q)
      ST_SWEEP: begin
        head_we    = 1'b1;
        head_waddr = sweep_q;
        head_wdata = mfd_pkg::NIL_LINK;
        sweep_d    = sweep_q + 1'b1;
        if (sweep_q == BktW'(mfd_pkg::Buckets - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          cmd_d = q_data_i;
          case (q_data_i.op)
            mfd_pkg::OP_ADD: state_d = ST_HEAD;
            mfd_pkg::OP_READ: begin
              if ({1'b0, q_data_i.sel} < total_q) begin
                state_d = ST_RDOUT;
              end else begin
                res_valid_d      = 1'b1;
                res_d.face_index = q_data_i.sel;
                res_d.face_total = total_q;
              end
            end
            mfd_pkg::OP_CLEAR: begin
              total_d     = '0;
              sweep_d     = '0;
              res_valid_d = 1'b1;
              state_d     = ST_SWEEP;
            end
            default: begin
              res_valid_d      = 1'b1;
              res_d.face_total = total_q;
            end
          endcase
        end
      end
      ST_HEAD: begin
        head_d = head_rdata;
        p_d    = head_rdata;
        state_d = (head_rdata < total_q) ? ST_CMP : ST_NEW;
      end
      ST_CMP: begin
        if (match) begin
          cnt_we             = 1'b1;
          res_valid_d        = 1'b1;
          res_d.face_index   = p_q[IdxW-1:0];
          res_d.face_class   = mfd_pkg::class_of(c_new, v_new);
          res_d.out_vertex_0 = b0;
          res_d.out_vertex_1 = b1;
          res_d.out_vertex_2 = b2;
          res_d.out_vertex_3 = b3;
          res_d.out_is_quad  = bq;
          res_d.face_total   = total_q;
          state_d            = ST_IDLE;
        end else begin
          p_d     = link_rdata;
          state_d = (link_rdata < total_q) ? ST_CMP : ST_NEW;
        end
      end
      ST_NEW: begin
        res_valid_d        = 1'b1;
        res_d.out_vertex_0 = cmd_q.c0;
        res_d.out_vertex_1 = cmd_q.c1;
        res_d.out_vertex_2 = cmd_q.c2;
        res_d.out_vertex_3 = cmd_q.c3;
        res_d.out_is_quad  = cmd_q.quad;
        state_d            = ST_IDLE;
        if (total_q == mfd_pkg::NIL_LINK) begin
          res_d.table_full = 1'b1;
          res_d.face_total = total_q;
        end else begin
          face_we          = 1'b1;
          cnt_we           = 1'b1;
          head_we          = 1'b1;
          cnt_waddr        = total_q[IdxW-1:0];
          cnt_wdata        = {2'd1, 1'b0, cmd_q.vis};
          total_d          = total_q + 1'b1;
          res_d.face_index = total_q[IdxW-1:0];
          res_d.is_new     = 1'b1;
          res_d.face_class = cmd_q.vis ? mfd_pkg::CLS_OUTER_VIS : mfd_pkg::CLS_OUTER_INVIS;
          res_d.face_total = total_d;
        end
      end
      ST_RDOUT: begin
        res_valid_d        = 1'b1;
        res_d.face_index   = cmd_q.sel;
        res_d.face_class   = mfd_pkg::class_of(c_old, v_old);
        res_d.out_vertex_0 = b0;
        res_d.out_vertex_1 = b1;
        res_d.out_vertex_2 = b2;
        res_d.out_vertex_3 = b3;
        res_d.out_is_quad  = bq;
        res_d.face_total   = total_q;
        state_d            = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    p_q    <= p_d;
    head_q <= head_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  mfd_ram #(.Width(mfd_pkg::FaceW), .Depth(mfd_pkg::FaceCapacity)) u_face_ram (
    .clk_i, .we_i(face_we), .waddr_i(total_q[IdxW-1:0]), .wdata_i(face_wdata),
    .raddr_i(rd_addr), .rdata_o(face_rdata)
  );

  mfd_ram #(.Width(TotW), .Depth(mfd_pkg::FaceCapacity)) u_link_ram (
    .clk_i, .we_i(face_we), .waddr_i(total_q[IdxW-1:0]), .wdata_i(head_q),
    .raddr_i(rd_addr), .rdata_o(link_rdata)
  );

  mfd_ram #(.Width(mfd_pkg::CntW), .Depth(mfd_pkg::FaceCapacity)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(rd_addr), .rdata_o(cnt_rdata)
  );

  mfd_ram #(.Width(TotW), .Depth(mfd_pkg::Buckets)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(q_data_i.bucket), .rdata_o(head_rdata)
  );
endmodule

>>> hw/rtl/mesh_face_dedup_classifier.sv
`timescale 1ns / 1ps
// channel   | signals                   | direction | transfer when
// ----------+---------------------------+-----------+------------------------------
// command   | start_i, busy_o, cmd_i    | in        | start_i high and busy_o low
// result    | res_valid_o, res_o        | out       | res_valid_o high (one cycle)
//
// add: reads the bucket head, then walks the chain one entry per cycle until a match
//   updates the counts or the chain ends; a new face is added unless the table is full
// read: stored face and class, or only the total for an index past the end; clear:
//   result next cycle, then a sweep of all 1024 bucket heads; reset starts with this sweep
// busy_o is high during a sweep and while the two-entry queue and front register are full
// results cannot be stalled; each shows for one cycle
module mesh_face_dedup_classifier (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  mfd_pkg::in_t  cmd_i,
  output logic          res_valid_o,
  output mfd_pkg::res_t res_o
);
  // front to queue
  logic          push, push_ready;
  mfd_pkg::cmd_t push_data;
  // queue to back
  logic          pop, pop_valid;
  mfd_pkg::cmd_t pop_data;
  // back holds off new commands while the head table is swept
  logic          sweeping;

  // canonical rotation and bucket pick
  mfd_front u_front (
    .clk_i, .rst_ni, .start_i, .cmd_i,
    .hold_i(sweeping), .busy_o,
    .push_o(push), .push_ready_i(push_ready), .push_data_o(push_data)
  );

  mfd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .push_ready_o(push_ready),
    .pop_i(pop), .pop_valid_o(pop_valid), .pop_data_o(pop_data)
  );

  // table lookup, insert, count update and result register
  mfd_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(pop_valid), .q_data_i(pop_data), .pop_o(pop),
    .sweeping_o(sweeping), .res_valid_o, .res_o
  );
endmodule
